// File: sv/dnl_pkg.sv
// dnl_pkg: request and status codes and controller states for duplicate_nonce_log.
// No dependencies.
`default_nettype none
package dnl_pkg;
   typedef enum logic [2:0] {
      REQ_CHECK  = 3'd0,
      REQ_SUBMIT = 3'd1,
      REQ_MERGE  = 3'd2,
      REQ_PJOB   = 3'd3,
      REQ_POLD   = 3'd4,
      REQ_CLEAR  = 3'd5,
      REQ_NOP6   = 3'd6,
      REQ_NOP7   = 3'd7
   } req_code_type;

   localparam logic [1:0] ST_DONE     = 2'd0;
   localparam logic [1:0] ST_NOTFOUND = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;

   localparam logic [31:0] TIMEOUT_RESET = 32'd300;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LAST,
      S_FIN,
      S_WRITE,
      S_OUT
   } state_type;
endpackage
`default_nettype wire

// File: sv/duplicate_nonce_log.sv
// duplicate_nonce_log: share log with a registered-read record memory and a scan sequencer.
// Depends on dnl_pkg.
//
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_type job_id nonce range_start range_end now_time
//  rsp     | out       | rsp_valid rsp_ready status answer_value removed_count
//  csr     | in        | csr_wr_en csr_wr_data (purge_timeout)
//
// Each item walks all ENTRIES slots through the record memory, one read a cycle, so the
// single read port sets the time: the scan in S_SCAN is followed by S_LAST, S_FIN,
// S_WRITE (SUBMIT and MERGE only) and S_OUT, which loads the result register.
// Reset empties the table at once (valid bits) and loads purge_timeout with 300.
// A result waits in the output register; the next item is taken the cycle after it has gone.
`default_nettype none
module duplicate_nonce_log #(
   parameter int ENTRIES = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [31:0] job_id,
   input  wire logic [31:0] nonce,
   input  wire logic [31:0] range_start,
   input  wire logic [31:0] range_end,
   input  wire logic [31:0] now_time,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       status,
   output logic [31:0]      answer_value,
   output logic [6:0]       removed_count,
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);
   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RW = 64 + 32 + 32 + 32;

   logic [RW-1:0]  mem [ENTRIES];
   logic [RW-1:0]  rd_ff;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   dnl_pkg::state_type state_ff, state_in;
   logic [AW:0]    cnt_ff, cnt_in;
   logic [AW-1:0]  rslot_ff;
   logic           rvalid_ff;

   logic [2:0]  typ_ff;
   logic [31:0] job_ff, non_ff, rs_ff, re_ff, now_ff;
   logic [31:0] timeout_ff;

   logic        hit_ff, hit_in, k0hit_ff, k0hit_in, any_ff, any_in, found_ff, found_in;
   logic        free_ff, free_in;
   logic [AW-1:0] hslot_ff, hslot_in, k0slot_ff, k0slot_in, fslot_ff, fslot_in;
   logic [31:0] hsent_ff, hsent_in, k0sent_ff, k0sent_in;
   logic [31:0] from_ff, from_in, to_ff, to_in, best_ff, best_in;
   logic [12:0] rem_ff, rem_in;

   logic        wr_en;
   logic [AW-1:0] wr_addr;
   logic [RW-1:0] wr_data;
   logic [31:0] wr_sent, wr_from, wr_to, wr_nonce;
   logic [AW-1:0] wslot_ff, wslot_in;
   logic        wok_ff, wok_in;

   logic        rsp_valid_ff;
   logic [1:0]  status_ff, status_in;
   logic [31:0] answer_ff, answer_in;
   logic [6:0]  rcnt_ff;
   logic        out_load;

   logic [31:0] e_job, e_non, e_sent, e_from, e_to;
   logic        e_val, e_job_eq;
   logic [31:0] mf, mt;

   assign e_job  = rd_ff[RW-1 -: 32];
   assign e_non  = rd_ff[RW-33 -: 32];
   assign e_sent = rd_ff[95:64];
   assign e_from = rd_ff[63:32];
   assign e_to   = rd_ff[31:0];
   assign e_val  = rvalid_ff && valid_ff[rslot_ff];
   assign e_job_eq = e_val && (e_job == job_ff);

   assign req_ready     = (state_ff == dnl_pkg::S_IDLE) && !rsp_valid_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign status        = status_ff;
   assign answer_value  = answer_ff;
   assign removed_count = rcnt_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dnl_pkg::S_IDLE;
         valid_ff     <= '0;
         timeout_ff   <= dnl_pkg::TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         rvalid_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         rvalid_ff <= (state_ff == dnl_pkg::S_SCAN);
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rslot_ff <= cnt_ff[AW-1:0];
      hit_ff <= hit_in;   k0hit_ff <= k0hit_in; any_ff <= any_in; found_ff <= found_in;
      free_ff <= free_in; hslot_ff <= hslot_in; k0slot_ff <= k0slot_in;
      fslot_ff <= fslot_in; hsent_ff <= hsent_in; k0sent_ff <= k0sent_in;
      from_ff <= from_in; to_ff <= to_in; best_ff <= best_in; rem_ff <= rem_in;
      wslot_ff <= wslot_in; wok_ff <= wok_in;
      status_ff <= status_in; answer_ff <= answer_in;
      if (out_load) begin
         rcnt_ff <= (rem_ff > 13'd127) ? 7'd127 : rem_ff[6:0];
      end
      if (req_valid && req_ready) begin
         typ_ff <= req_type; job_ff <= job_id; non_ff <= nonce;
         rs_ff <= range_start; re_ff <= range_end; now_ff <= now_time;
      end
   end

   // merge finish: range adjacency rules
   always_comb begin
      mt = to_ff;
      mf = from_ff;
      if (rs_ff < re_ff) begin
         if (to_ff == 32'd0 || rs_ff == to_ff + 32'd1) begin
            mt = re_ff;
         end
         if (from_ff == 32'd0) begin
            mf = (rs_ff != 32'd0) ? rs_ff : 32'd1;
         end else if (rs_ff < from_ff || re_ff == from_ff - 32'd1) begin
            mf = rs_ff;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      valid_in = valid_ff;
      cnt_in = cnt_ff;
      hit_in = hit_ff; k0hit_in = k0hit_ff; any_in = any_ff; found_in = found_ff;
      free_in = free_ff; hslot_in = hslot_ff; k0slot_in = k0slot_ff; fslot_in = fslot_ff;
      hsent_in = hsent_ff; k0sent_in = k0sent_ff; from_in = from_ff; to_in = to_ff;
      best_in = best_ff; rem_in = rem_ff; wslot_in = wslot_ff; wok_in = wok_ff;
      status_in = status_ff; answer_in = answer_ff;
      out_load = 1'b0;
      wr_en = 1'b0;
      wr_addr = wslot_ff;
      wr_sent = now_ff; wr_from = rs_ff; wr_to = non_ff; wr_nonce = non_ff;
      if (typ_ff == dnl_pkg::REQ_MERGE) begin
         wr_sent = k0sent_ff; wr_from = from_ff; wr_to = to_ff; wr_nonce = 32'd0;
      end
      wr_data = {job_ff, wr_nonce, wr_sent, wr_from, wr_to};

      // accumulate over the entry read in the previous cycle
      if (rvalid_ff) begin
         if (!valid_ff[rslot_ff] && !free_ff) begin
            free_in = 1'b1; fslot_in = rslot_ff;
         end
         if (e_job_eq && e_non == non_ff && !hit_ff) begin
            hit_in = 1'b1; hslot_in = rslot_ff; hsent_in = e_sent;
         end
         if (e_job_eq && e_non == 32'd0 && !k0hit_ff) begin
            k0hit_in = 1'b1; k0slot_in = rslot_ff; k0sent_in = e_sent;
         end
         if (e_job_eq && e_sent != 32'd0) begin
            found_in = 1'b1;
            if (!found_ff || e_non > best_ff) best_in = e_non;
         end
         if (e_job_eq && e_to != 32'd0) begin
            any_in = 1'b1;
            if (e_to > to_ff) to_in = e_to;
            if (e_from < from_ff || from_ff == 32'd0) from_in = e_from;
         end
         if (e_val) begin
            if ((typ_ff == dnl_pkg::REQ_PJOB && e_job == job_ff)
                || (typ_ff == dnl_pkg::REQ_POLD && (now_ff - e_sent) > timeout_ff)
                || typ_ff == dnl_pkg::REQ_CLEAR) begin
               valid_in[rslot_ff] = 1'b0;
               rem_in = rem_ff + 13'd1;
            end
         end
      end

      case (state_ff)
         dnl_pkg::S_IDLE: begin
            cnt_in = '0;
            if (req_valid && req_ready) begin
               hit_in = 1'b0; k0hit_in = 1'b0; any_in = 1'b0; found_in = 1'b0;
               free_in = 1'b0; from_in = '0; to_in = '0; best_in = '0; rem_in = '0;
               state_in = dnl_pkg::S_SCAN;
            end
         end
         dnl_pkg::S_SCAN: begin
            if (cnt_ff == (AW+1)'(ENTRIES - 1)) begin
               state_in = dnl_pkg::S_LAST;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         dnl_pkg::S_LAST: begin
            state_in = dnl_pkg::S_FIN;
         end
         dnl_pkg::S_FIN: begin
            status_in = dnl_pkg::ST_DONE;
            answer_in = '0;
            state_in = dnl_pkg::S_OUT;
            case (typ_ff)
               dnl_pkg::REQ_CHECK: begin
                  if (non_ff != 32'd0) begin
                     if (hit_ff) answer_in = hsent_ff;
                     else status_in = dnl_pkg::ST_NOTFOUND;
                  end else begin
                     if (found_ff) answer_in = best_ff;
                     else status_in = dnl_pkg::ST_NOTFOUND;
                  end
               end
               dnl_pkg::REQ_SUBMIT: begin
                  wok_in = hit_ff || free_ff;
                  wslot_in = hit_ff ? hslot_ff : fslot_ff;
                  if (!(hit_ff || free_ff)) status_in = dnl_pkg::ST_FULL;
                  state_in = dnl_pkg::S_WRITE;
               end
               dnl_pkg::REQ_MERGE: begin
                  wok_in = k0hit_ff || free_ff;
                  wslot_in = k0hit_ff ? k0slot_ff : fslot_ff;
                  if (!(k0hit_ff || free_ff)) status_in = dnl_pkg::ST_FULL;
                  k0sent_in = (any_ff && k0hit_ff) ? k0sent_ff : 32'd0;
                  from_in = mf;
                  to_in = mt;
                  state_in = dnl_pkg::S_WRITE;
               end
               default: begin
               end
            endcase
         end
         dnl_pkg::S_WRITE: begin
            if (wok_ff) begin
               wr_en = 1'b1;
               valid_in[wslot_ff] = 1'b1;
            end
            state_in = dnl_pkg::S_OUT;
         end
         dnl_pkg::S_OUT: begin
            out_load = 1'b1;
            state_in = dnl_pkg::S_IDLE;
         end
         default: begin
            state_in = dnl_pkg::S_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

// File: bench/tb_top.sv
// tb_top: self-checking bench for duplicate_nonce_log; predicts each result from its own
// copy of the share table and compares field by field. Depends on dnl_pkg and the DUT.
`default_nettype none
module tb_top;
   localparam int SLOTS = 64;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] answer;
      logic [6:0]  removed;
   } result_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [2:0]  req_type = 0;
   logic [31:0] job_id = 0, nonce = 0, range_start = 0, range_end = 0, now_time = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [1:0]  status;
   logic [31:0] answer_value;
   logic [6:0]  removed_count;
   logic        csr_wr_en = 0;
   logic [31:0] csr_wr_data = 0;

   duplicate_nonce_log dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .job_id(job_id), .nonce(nonce), .range_start(range_start),
      .range_end(range_end), .now_time(now_time),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .status(status),
      .answer_value(answer_value), .removed_count(removed_count),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // shadow table
   logic [31:0] timeout_q;
   bit          live [SLOTS];
   logic [31:0] rec_job [SLOTS];
   logic [31:0] rec_nonce [SLOTS];
   logic [31:0] rec_sent [SLOTS];
   logic [31:0] rec_from [SLOTS];
   logic [31:0] rec_to [SLOTS];

   result_type pending_results[$];
   int      errors = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      hold_cycles = 0;
   logic [31:0] clock_now = 1000;

   initial forever #5 clock = ~clock;

   initial begin
      #50_000_000;
      $display("duplicate_nonce_log test failed");
      $finish;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
   endtask

   function automatic int lookup(input logic [31:0] j, input logic [31:0] n);
      for (int i = 0; i < SLOTS; i++)
         if (live[i] && rec_job[i] == j && rec_nonce[i] == n) return i;
      return -1;
   endfunction

   function automatic int first_free();
      for (int i = 0; i < SLOTS; i++)
         if (!live[i]) return i;
      return -1;
   endfunction

   function automatic result_type predict_log(input logic [2:0] op, input logic [31:0] j,
         input logic [31:0] n, input logic [31:0] rs, input logic [31:0] re,
         input logic [31:0] t);
      result_type r;
      int      slot;
      bit      hit;
      logic [31:0] lo, hi, snt;
      int      cnt;
      bit      kill;
      r = '0;
      cnt = 0;
      case (op)
         dnl_pkg::REQ_CHECK: begin
            if (n != 0) begin
               slot = lookup(j, n);
               if (slot >= 0) r.answer = rec_sent[slot];
               else r.status = dnl_pkg::ST_NOTFOUND;
            end else begin
               hit = 0;
               for (int i = 0; i < SLOTS; i++)
                  if (live[i] && rec_job[i] == j && rec_sent[i] != 0) begin
                     if (!hit || rec_nonce[i] > r.answer) r.answer = rec_nonce[i];
                     hit = 1;
                  end
               if (!hit) r.status = dnl_pkg::ST_NOTFOUND;
            end
         end
         dnl_pkg::REQ_SUBMIT: begin
            slot = lookup(j, n);
            if (slot < 0) slot = first_free();
            if (slot < 0) r.status = dnl_pkg::ST_FULL;
            else begin
               live[slot] = 1; rec_job[slot] = j; rec_nonce[slot] = n;
               rec_sent[slot] = t; rec_from[slot] = rs; rec_to[slot] = n;
            end
         end
         dnl_pkg::REQ_MERGE: begin
            lo = 0; hi = 0; snt = 0; hit = 0;
            for (int i = 0; i < SLOTS; i++)
               if (live[i] && rec_job[i] == j && rec_to[i] > 0) begin
                  hit = 1;
                  if (rec_to[i] > hi) hi = rec_to[i];
                  if (rec_from[i] < lo || lo == 0) lo = rec_from[i];
               end
            slot = lookup(j, 0);
            if (hit && slot >= 0) snt = rec_sent[slot];
            if (rs < re) begin
               if (hi == 0 || rs == hi + 32'd1) hi = re;
               if (lo == 0) lo = (rs != 0) ? rs : 32'd1;
               else if (rs < lo || re == lo - 32'd1) lo = rs;
            end
            if (slot < 0) slot = first_free();
            if (slot < 0) r.status = dnl_pkg::ST_FULL;
            else begin
               live[slot] = 1; rec_job[slot] = j; rec_nonce[slot] = 0;
               rec_sent[slot] = snt; rec_from[slot] = lo; rec_to[slot] = hi;
            end
         end
         dnl_pkg::REQ_PJOB, dnl_pkg::REQ_POLD, dnl_pkg::REQ_CLEAR: begin
            for (int i = 0; i < SLOTS; i++)
               if (live[i]) begin
                  if (op == dnl_pkg::REQ_PJOB) kill = rec_job[i] == j;
                  else if (op == dnl_pkg::REQ_POLD) kill = (t - rec_sent[i]) > timeout_q;
                  else kill = 1;
                  if (kill) begin
                     live[i] = 0;
                     cnt++;
                  end
               end
            r.removed = (cnt > 127) ? 7'd127 : cnt[6:0];
         end
         default: ;
      endcase
      return r;
   endfunction

   // one item, held until accepted; valid drops only when the sender idles
   task automatic send_item(input logic [2:0] op, input logic [31:0] j, input logic [31:0] n,
         input logic [31:0] rs, input logic [31:0] re, input logic [31:0] t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1; req_type <= op; job_id <= j; nonce <= n;
      range_start <= rs; range_end <= re; now_time <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_results.push_back(predict_log(op, j, n, rs, re, t));
      @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) report("unexpected result", 32'(status), 32'd0);
         else begin
            result_type e;
            e = pending_results.pop_front();
            if (status !== e.status) report("status", 32'(status), 32'(e.status));
            if (answer_value !== e.answer) report("answer_value", answer_value, e.answer);
            if (removed_count !== e.removed)
               report("removed_count", 32'(removed_count), 32'(e.removed));
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 0;
         hold_cycles <= hold_cycles - 1;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic drain();
      req_valid <= 0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (80) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [31:0] v);
      drain();
      csr_wr_en <= 1; csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 0;
      timeout_q = v;
   endtask

   task automatic tick(input int dt);
      clock_now += dt;
   endtask

   task automatic test_directed();
      send_item(dnl_pkg::REQ_CHECK, 32'h0, 32'h0, 0, 0, 0);
      send_item(dnl_pkg::REQ_SUBMIT, 32'hffffffff, 32'hffffffff, 32'hffffffff, 0,
                32'hffffffff);
      send_item(dnl_pkg::REQ_CHECK, 32'hffffffff, 32'hffffffff, 0, 0, 0);
      send_item(dnl_pkg::REQ_CHECK, 32'hffffffff, 32'h0, 0, 0, 0);
      send_item(dnl_pkg::REQ_CHECK, 32'hfffffffe, 32'hffffffff, 0, 0, 0);
      send_item(dnl_pkg::REQ_SUBMIT, 32'h5, 32'h10, 32'h1, 0, 0);   // zero send time
      send_item(dnl_pkg::REQ_CHECK, 32'h5, 32'h0, 0, 0, 0);
      send_item(dnl_pkg::REQ_MERGE, 32'h5, 0, 32'h11, 32'h40, 0);   // adjacent above
      send_item(dnl_pkg::REQ_MERGE, 32'h5, 0, 32'h0, 32'h0, 0);
      send_item(dnl_pkg::REQ_MERGE, 32'h9, 0, 32'h0, 32'h20, 0);    // new job, start zero
      send_item(dnl_pkg::REQ_MERGE, 32'h9, 0, 32'h20, 32'h10, 0);
      send_item(dnl_pkg::REQ_MERGE, 32'h7, 0, 32'hfffffffe, 32'hffffffff, 0);
      send_item(dnl_pkg::REQ_SUBMIT, 32'h5, 32'h0, 32'h0, 0, 32'h3);
      send_item(dnl_pkg::REQ_CHECK, 32'h5, 32'h0, 0, 0, 0);
      send_item(dnl_pkg::REQ_PJOB, 32'h5, 0, 0, 0, 0);
      send_item(dnl_pkg::REQ_NOP6, 32'h1, 32'h1, 1, 1, 1);
      send_item(dnl_pkg::REQ_NOP7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                32'hffffffff);
      send_item(dnl_pkg::REQ_POLD, 0, 0, 0, 0, 32'h0);
      send_item(dnl_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
   endtask

   task automatic test_full_table();
      for (int i = 0; i < SLOTS + 2; i++)
         send_item(dnl_pkg::REQ_SUBMIT, 32'h77, i + 1, i, 0, clock_now + i);
      send_item(dnl_pkg::REQ_MERGE, 32'h78, 0, 1, 5, 0);
      send_item(dnl_pkg::REQ_SUBMIT, 32'h77, 32'h3, 0, 0, 32'h1234);   // overwrite while full
      send_item(dnl_pkg::REQ_CHECK, 32'h77, 32'h0, 0, 0, 0);
      send_item(dnl_pkg::REQ_POLD, 0, 0, 0, 0, clock_now + 40);
      send_item(dnl_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
   endtask

   task automatic test_backpressure();
      drain();
      hold_cycles = 2000;
      for (int i = 0; i < 12; i++)
         send_item(dnl_pkg::REQ_SUBMIT, $urandom_range(3), $urandom, $urandom, $urandom,
                   $urandom);
      drain();
      send_item(dnl_pkg::REQ_CLEAR, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random(input int count);
      logic [31:0] j, n, rs, re;
      logic [2:0]  op;
      int          pick;
      for (int k = 0; k < count; k++) begin
         j = ($urandom_range(9) == 0) ? $urandom : $urandom_range(5);
         n = ($urandom_range(3) == 0) ? 0 : (($urandom_range(4) == 0) ? $urandom :
             $urandom_range(40));
         rs = $urandom; re = $urandom;
         if ($urandom_range(1)) begin
            rs = $urandom_range(60); re = rs + $urandom_range(20) - 2;
         end
         if ($urandom_range(2) == 0) tick($urandom_range(200));
         pick = $urandom_range(99);
         if (pick < 32) op = dnl_pkg::REQ_SUBMIT;
         else if (pick < 58) op = dnl_pkg::REQ_CHECK;
         else if (pick < 82) op = dnl_pkg::REQ_MERGE;
         else if (pick < 88) op = dnl_pkg::REQ_PJOB;
         else if (pick < 94) op = dnl_pkg::REQ_POLD;
         else if (pick < 96) op = dnl_pkg::REQ_CLEAR;
         else op = $urandom_range(1) ? dnl_pkg::REQ_NOP6 : dnl_pkg::REQ_NOP7;
         send_item(op, j, n, rs, re, ($urandom_range(19) == 0) ? $urandom : clock_now);
      end
   endtask

   initial begin
      timeout_q = dnl_pkg::TIMEOUT_RESET;
      for (int i = 0; i < SLOTS; i++) live[i] = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      send_idle_pct = 9; recv_idle_pct = 69;
      test_directed();
      test_full_table();
      test_random(600);
      write_timeout(32'h0);
      send_idle_pct = 69; recv_idle_pct = 9;
      test_random(500);
      test_backpressure();
      write_timeout(32'hffffffff);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(300);
      write_timeout(32'd100);
      test_random(400);
      drain();

      if (errors == 0)
         $display("duplicate_nonce_log test passed");
      else
         $display("duplicate_nonce_log test failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: filelist.f
sv/dnl_pkg.sv
sv/duplicate_nonce_log.sv
bench/tb_top.sv
